/* hdl/assert_macros.svh */
// assertion shorthands shared by the formatter modules
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition checked at every clock edge out of reset
`define ITA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define ITA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* hdl/ita_pkg.sv */
// shared constants, types and the digit-to-character function of the formatter
// no dependencies
package ita_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int MAX_CHARS   = 64;
	localparam int WIDTH_LIMIT = 64;
	localparam int PREC_LIMIT  = 60;
	localparam int BASE_MIN    = 2;
	localparam int BASE_MAX    = 36;
	localparam int BASE_OCT    = 8;
	localparam int BASE_HEX    = 16;

	localparam int DIG_W     = 6;                        // base and digit value
	localparam int FW_W      = 7;                        // width field
	localparam int PREC_W    = 6;                        // precision field
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int ND_W      = $clog2(VALUE_BITS + 1);
	localparam int CNT_W     = 8;                        // pad, precision and total counts
	localparam int CHR_CNT_W = $clog2(MAX_CHARS + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	typedef struct packed {
		logic                 busy;
		logic                 digit_vld;
		logic [DIG_W-1:0]     digit;
		logic                 done;
	} div_stat_t;

	typedef struct packed {
		logic                 err;
		logic [7:0]           sign_chr;   // CH_NUL when no sign is printed
		logic [1:0]           pfx_len;
		logic                 zpad;
		logic                 left;
		logic                 upper;
		logic [CNT_W-1:0]     pad;
		logic [CNT_W-1:0]     prec_zeros;
		logic [ND_W-1:0]      ndig;
		logic [CHR_CNT_W-1:0] nchars;
	} emit_cfg_t;

	function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
		logic [7:0] d8;
		d8 = {{(8 - DIG_W){1'b0}}, d};
		if (d8 < 8'd10)
			return CH_ZERO + d8;
		else
			return (upper ? CH_UPPER_A : CH_LOWER_A) + d8 - 8'd10;
	endfunction

endpackage

/* hdl/integer_to_ascii_formatter.sv */
// Integer to ASCII formatter. Each input item is one printf-style integer conversion;
// the text comes out one character per output item, last set on the final one, or a
// single item with bad_base set when the base is outside 2..36. The magnitude is
// converted by a bit-serial divider one digit at a time. One item is converted at a
// time; the next is accepted once the last character has been loaded into the output
// register. Top level of the block; depends on ita_pkg, ita_divider, ita_digit_stack,
// ita_emitter and assert_macros.svh.
`include "assert_macros.svh"

module integer_to_ascii_formatter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ita_pkg::VALUE_BITS-1:0]     value,
	input  logic [ita_pkg::DIG_W-1:0]          base,
	input  logic [ita_pkg::FW_W-1:0]           width,
	input  logic [ita_pkg::PREC_W-1:0]         precision,
	input  logic                               left_align,
	input  logic                               plus_sign,
	input  logic                               space_sign,
	input  logic                               alt_prefix,
	input  logic                               zero_pad,
	input  logic                               upper_case,
	input  logic                               is_signed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         character,
	output logic                               last,
	output logic                               bad_base
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                        state_q;
	logic [ita_pkg::ND_W-1:0]          nd_q;
	logic [ita_pkg::FW_W-1:0]          width_q;
	logic [ita_pkg::PREC_W-1:0]        prec_q;
	logic [7:0]                        sign_chr_q;
	logic [1:0]                        pfx_len_q;
	logic                              zpad_q;
	logic                              left_q;
	logic                              upper_q;

	logic                              accept;
	logic                              base_ok;
	logic                              neg;
	logic [7:0]                        sign_chr;
	logic [ita_pkg::VALUE_BITS-1:0]    mag;
	logic [1:0]                        pfx_len;

	logic [ita_pkg::CNT_W-1:0]         width_sat;
	logic [ita_pkg::CNT_W-1:0]         prec_sat;
	logic [ita_pkg::CNT_W-1:0]         nd_ext;
	logic [ita_pkg::CNT_W-1:0]         prec_eff;
	logic [ita_pkg::CNT_W-1:0]         fixed_len;
	logic [ita_pkg::CNT_W-1:0]         total;

	ita_pkg::div_stat_t                div_stat;
	ita_pkg::emit_cfg_t                emit_cfg;
	logic                              emit_load;
	logic                              emit_busy;
	logic                              stk_pop;
	logic [ita_pkg::DIG_W-1:0]         stk_top;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		base_ok = base inside {[ita_pkg::BASE_MIN:ita_pkg::BASE_MAX]};
		neg     = is_signed && value[ita_pkg::VALUE_BITS-1];
		mag     = neg ? (~value + 1'b1) : value;
		if (neg)
			sign_chr = ita_pkg::CH_MINUS;
		else if (is_signed && plus_sign)
			sign_chr = ita_pkg::CH_PLUS;
		else if (is_signed && space_sign)
			sign_chr = ita_pkg::CH_SPACE;
		else
			sign_chr = ita_pkg::CH_NUL;
		if (alt_prefix && base == ita_pkg::DIG_W'(ita_pkg::BASE_HEX))
			pfx_len = 2'd2;
		else if (alt_prefix && base == ita_pkg::DIG_W'(ita_pkg::BASE_OCT))
			pfx_len = 2'd1;
		else
			pfx_len = 2'd0;
	end

	// field layout once the digit count is known
	always_comb begin
		width_sat = (width_q > ita_pkg::FW_W'(ita_pkg::WIDTH_LIMIT))
		          ? ita_pkg::CNT_W'(ita_pkg::WIDTH_LIMIT)
		          : ita_pkg::CNT_W'(width_q);
		prec_sat  = (prec_q > ita_pkg::PREC_W'(ita_pkg::PREC_LIMIT))
		          ? ita_pkg::CNT_W'(ita_pkg::PREC_LIMIT)
		          : ita_pkg::CNT_W'(prec_q);
		nd_ext    = ita_pkg::CNT_W'(nd_q);
		prec_eff  = (prec_sat > nd_ext) ? prec_sat : nd_ext;
		fixed_len = prec_eff + ita_pkg::CNT_W'(pfx_len_q)
		          + ita_pkg::CNT_W'(sign_chr_q != ita_pkg::CH_NUL);
		total     = (width_sat > fixed_len) ? width_sat : fixed_len;

		emit_cfg            = '0;
		if (state_q == ST_LOAD) begin
			emit_cfg.sign_chr   = sign_chr_q;
			emit_cfg.pfx_len    = pfx_len_q;
			emit_cfg.zpad       = zpad_q;
			emit_cfg.left       = left_q;
			emit_cfg.upper      = upper_q;
			emit_cfg.pad        = total - fixed_len;
			emit_cfg.prec_zeros = prec_eff - nd_ext;
			emit_cfg.ndig       = nd_q;
			emit_cfg.nchars     = (total > ita_pkg::CNT_W'(ita_pkg::MAX_CHARS))
			                    ? ita_pkg::CHR_CNT_W'(ita_pkg::MAX_CHARS)
			                    : ita_pkg::CHR_CNT_W'(total);
		end else begin
			emit_cfg.err        = 1'b1;
			emit_cfg.nchars     = ita_pkg::CHR_CNT_W'(1);
		end
	end

	assign emit_load = (accept && !base_ok) || (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nd_q    <= '0;
		end else begin
			if (accept)
				nd_q <= '0;
			else if (div_stat.digit_vld)
				nd_q <= nd_q + 1'b1;
			case (state_q)
				ST_IDLE: if (accept) state_q <= base_ok ? ST_DIV : ST_EMIT;
				ST_DIV:  if (div_stat.done) state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_EMIT;
				ST_EMIT: if (!emit_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q    <= width;
			prec_q     <= precision;
			sign_chr_q <= sign_chr;
			pfx_len_q  <= pfx_len;
			zpad_q     <= zero_pad && !left_align;
			left_q     <= left_align;
			upper_q    <= upper_case;
		end
	end

	ita_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && base_ok),
		.mag    (mag),
		.base   (base),
		.stat   (div_stat)
	);

	ita_digit_stack u_stack (
		.clk  (clk),
		.push (div_stat.digit_vld),
		.pop  (stk_pop),
		.din  (div_stat.digit),
		.top  (stk_top)
	);

	ita_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.cfg       (emit_cfg),
		.top_digit (stk_top),
		.pop       (stk_pop),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last),
		.bad_base  (bad_base)
	);

	`ITA_ASSERT_IMP(a_ready_when_quiet, in_ready, !div_stat.busy && !emit_busy,
		"item accepted while a conversion is running")
	`ITA_ASSERT_IMP(a_push_pop_apart, div_stat.digit_vld, !stk_pop, "digit push and pop collide")
	`ITA_ASSERT(a_digit_count_bound, nd_q <= ita_pkg::ND_W'(ita_pkg::VALUE_BITS),
		"more digits than value bits")

endmodule

/* hdl/ita_divider.sv */
// bit-serial restoring divider: peels one digit at a time, least significant first
// depends on ita_pkg and assert_macros.svh
`include "assert_macros.svh"

module ita_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ita_pkg::VALUE_BITS-1:0]     mag,
	input  logic [ita_pkg::DIG_W-1:0]          base,
	output ita_pkg::div_stat_t                 stat
);

	logic                              busy_q;
	logic [ita_pkg::BIT_CNT_W-1:0]     cnt_q;
	logic [ita_pkg::VALUE_BITS-1:0]    quo_q;
	logic [ita_pkg::DIG_W-1:0]         rem_q;
	logic [ita_pkg::DIG_W-1:0]         base_q;

	logic [ita_pkg::DIG_W:0]           trial;
	logic                              ge;
	logic [ita_pkg::DIG_W-1:0]         rem_nx;
	logic [ita_pkg::VALUE_BITS-1:0]    quo_nx;
	logic                              step_end;

	always_comb begin
		trial    = {rem_q, quo_q[ita_pkg::VALUE_BITS-1]};
		ge       = trial >= {1'b0, base_q};
		rem_nx   = ge ? ita_pkg::DIG_W'(trial - {1'b0, base_q})
		              : trial[ita_pkg::DIG_W-1:0];
		quo_nx   = {quo_q[ita_pkg::VALUE_BITS-2:0], ge};
		step_end = busy_q && (cnt_q == ita_pkg::BIT_CNT_W'(ita_pkg::VALUE_BITS - 1));
	end

	assign stat.busy      = busy_q;
	assign stat.digit_vld = step_end;
	assign stat.digit     = rem_nx;
	assign stat.done      = step_end && (quo_nx == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (step_end) begin
				cnt_q  <= '0;
				busy_q <= quo_nx != '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= mag;
			rem_q  <= '0;
			base_q <= base;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			// remainder restarts at zero for the next digit
			rem_q <= step_end ? '0 : rem_nx;
		end
	end

	`ITA_ASSERT_IMP(a_digit_below_base, stat.digit_vld, stat.digit < base_q, "digit not below base")
	`ITA_ASSERT_IMP(a_no_restart_busy, start, !busy_q, "divider restarted while busy")
	`ITA_ASSERT_IMP(a_idle_count_clear, !busy_q, cnt_q == '0, "bit count left over while idle")

endmodule

/* hdl/ita_digit_stack.sv */
// shift-line stack: digits pushed least significant first, popped most significant first
// depends on ita_pkg
module ita_digit_stack (
	input  logic                          clk,
	input  logic                          push,
	input  logic                          pop,
	input  logic [ita_pkg::DIG_W-1:0]     din,
	output logic [ita_pkg::DIG_W-1:0]     top
);

	logic [ita_pkg::DIG_W-1:0] stk_q [ita_pkg::VALUE_BITS];

	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= din;
			for (int i = 1; i < ita_pkg::VALUE_BITS; i++)
				stk_q[i] <= stk_q[i-1];
		end else if (pop) begin
			for (int i = 0; i < ita_pkg::VALUE_BITS - 1; i++)
				stk_q[i] <= stk_q[i+1];
		end
	end

	assign top = stk_q[0];

endmodule

/* hdl/ita_emitter.sv */
// character sequencer: walks the text sections and drives the output register
// depends on ita_pkg and assert_macros.svh
`include "assert_macros.svh"

module ita_emitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ita_pkg::emit_cfg_t            cfg,
	input  logic [ita_pkg::DIG_W-1:0]     top_digit,
	output logic                          pop,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    character,
	output logic                          last,
	output logic                          bad_base
);

	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_LEAD  = 4'd1;
	localparam logic [3:0] PH_SIGN  = 4'd2;
	localparam logic [3:0] PH_PFX0  = 4'd3;
	localparam logic [3:0] PH_PFXX  = 4'd4;
	localparam logic [3:0] PH_ZPAD  = 4'd5;
	localparam logic [3:0] PH_PREC  = 4'd6;
	localparam logic [3:0] PH_DIG   = 4'd7;
	localparam logic [3:0] PH_TRAIL = 4'd8;
	localparam logic [3:0] PH_ERR   = 4'd9;

	logic [3:0]                        ph_q;
	logic [ita_pkg::CHR_CNT_W-1:0]     left_cnt_q;
	logic [ita_pkg::CNT_W-1:0]         pad_q;
	logic [ita_pkg::CNT_W-1:0]         precz_q;
	logic [ita_pkg::ND_W-1:0]          nd_q;
	logic [7:0]                        sign_q;
	logic [1:0]                        pfx_q;
	logic                              zpad_q;
	logic                              lalign_q;
	logic                              upper_q;
	logic                              out_vld_q;
	logic [7:0]                        char_q;
	logic                              last_q;
	logic                              bad_q;

	logic                              want;
	logic [7:0]                        ch;
	logic [3:0]                        ph_nx;
	logic                              slot_free;
	logic                              fire;

	always_comb begin
		want  = 1'b0;
		ch    = ita_pkg::CH_SPACE;
		ph_nx = PH_IDLE;
		case (ph_q)
			PH_LEAD: begin
				want  = !lalign_q && !zpad_q && (pad_q != '0);
				ph_nx = PH_SIGN;
			end
			PH_SIGN: begin
				want  = sign_q != ita_pkg::CH_NUL;
				ch    = sign_q;
				ph_nx = PH_PFX0;
			end
			PH_PFX0: begin
				want  = pfx_q != 2'd0;
				ch    = ita_pkg::CH_ZERO;
				ph_nx = PH_PFXX;
			end
			PH_PFXX: begin
				want  = pfx_q == 2'd2;
				ch    = ita_pkg::CH_X;
				ph_nx = PH_ZPAD;
			end
			PH_ZPAD: begin
				want  = zpad_q && (pad_q != '0);
				ch    = ita_pkg::CH_ZERO;
				ph_nx = PH_PREC;
			end
			PH_PREC: begin
				want  = precz_q != '0;
				ch    = ita_pkg::CH_ZERO;
				ph_nx = PH_DIG;
			end
			PH_DIG: begin
				want  = nd_q != '0;
				ch    = ita_pkg::digit_char(top_digit, upper_q);
				ph_nx = PH_TRAIL;
			end
			PH_TRAIL: begin
				want  = lalign_q && (pad_q != '0);
				ph_nx = PH_IDLE;
			end
			PH_ERR: begin
				want  = 1'b1;
				ch    = ita_pkg::CH_NUL;
				ph_nx = PH_IDLE;
			end
			default: begin
				want  = 1'b0;
				ph_nx = PH_IDLE;
			end
		endcase
	end

	assign slot_free = !out_vld_q || out_ready;
	assign fire      = want && slot_free;
	assign pop       = fire && (ph_q == PH_DIG);
	assign busy      = ph_q != PH_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_IDLE;
			left_cnt_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load) begin
				ph_q       <= cfg.err ? PH_ERR : PH_LEAD;
				left_cnt_q <= cfg.nchars;
			end else if (ph_q != PH_IDLE) begin
				if (fire) begin
					left_cnt_q <= left_cnt_q - 1'b1;
					// stop at the character budget; single-character sections move on
					if (left_cnt_q == ita_pkg::CHR_CNT_W'(1))
						ph_q <= PH_IDLE;
					else if (ph_q == PH_SIGN || ph_q == PH_PFX0 || ph_q == PH_PFXX ||
					         ph_q == PH_ERR)
						ph_q <= ph_nx;
				end else if (!want) begin
					ph_q <= ph_nx;
				end
			end
			if (fire)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pad_q    <= cfg.pad;
			precz_q  <= cfg.prec_zeros;
			nd_q     <= cfg.ndig;
			sign_q   <= cfg.sign_chr;
			pfx_q    <= cfg.pfx_len;
			zpad_q   <= cfg.zpad;
			lalign_q <= cfg.left;
			upper_q  <= cfg.upper;
		end else if (fire) begin
			if (ph_q == PH_LEAD || ph_q == PH_ZPAD || ph_q == PH_TRAIL)
				pad_q <= pad_q - 1'b1;
			if (ph_q == PH_PREC)
				precz_q <= precz_q - 1'b1;
			if (ph_q == PH_DIG)
				nd_q <= nd_q - 1'b1;
		end
		if (fire) begin
			char_q <= ch;
			last_q <= left_cnt_q == ita_pkg::CHR_CNT_W'(1);
			bad_q  <= ph_q == PH_ERR;
		end
	end

	assign out_valid = out_vld_q;
	assign character = char_q;
	assign last      = last_q;
	assign bad_base  = bad_q;

	`ITA_ASSERT_IMP(a_idle_no_budget, ph_q == PH_IDLE, left_cnt_q == '0, "budget left while idle")
	`ITA_ASSERT_IMP(a_load_when_idle, load, ph_q == PH_IDLE, "load while sequencing")
	`ITA_ASSERT_IMP(a_err_item_shape, out_vld_q && bad_q,
		last_q && (char_q == ita_pkg::CH_NUL), "error item not a lone nul")

endmodule
